/* sv/cdte_pkg.sv */
// ----------------------------------------------------------------------------
// cdte_pkg
// shared types, constants and calendar tables for the datetime-to-epoch pipe
// ----------------------------------------------------------------------------
`default_nettype none

package cdte_pkg;

  localparam int unsigned YEAR_MIN      = 2000;
  localparam int unsigned YEAR_MAX      = 2099;
  // days from 1970-01-01 to 2000-01-01
  localparam int unsigned DAYS_TO_Y2K   = 10957;
  localparam int unsigned DAYS_PER_YEAR = 365;
  localparam int unsigned SECS_PER_DAY  = 86400;
  localparam int unsigned SECS_PER_HOUR = 3600;
  localparam int unsigned SECS_PER_MIN  = 60;

  localparam int unsigned DAYS_W  = 16;
  localparam int unsigned TOD_W   = 17;
  localparam int unsigned EPOCH_W = 32;

  // raw input item
  typedef struct packed {
    logic [5:0]  second;
    logic [5:0]  minute;
    logic [5:0]  hour;
    logic [5:0]  day;
    logic [3:0]  month;
    logic [11:0] year;
  } datetime_t;

  // after field checks
  typedef struct packed {
    logic       ok;
    logic       leap;
    logic [6:0] yoff;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } chk_t;

  // after day count and time of day
  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
  } days_t;

  // after scaling days to seconds
  typedef struct packed {
    logic               ok;
    logic [EPOCH_W-1:0] prod;
    logic [TOD_W-1:0]   tod;
  } prod_t;

  // result item
  typedef struct packed {
    logic               valid_res;
    logic [EPOCH_W-1:0] unix_time;
  } result_t;

  // month length in a common year, zero for codes that are not a month
  function automatic logic [4:0] month_len(input logic [3:0] m);
    logic [4:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // days in a common year before the first of month m
  function automatic logic [8:0] days_before_month(input logic [3:0] m);
    logic [8:0] cum;
    case (m)
      4'd1:    cum = 9'd0;
      4'd2:    cum = 9'd31;
      4'd3:    cum = 9'd59;
      4'd4:    cum = 9'd90;
      4'd5:    cum = 9'd120;
      4'd6:    cum = 9'd151;
      4'd7:    cum = 9'd181;
      4'd8:    cum = 9'd212;
      4'd9:    cum = 9'd243;
      4'd10:   cum = 9'd273;
      4'd11:   cum = 9'd304;
      4'd12:   cum = 9'd334;
      default: cum = 9'd0;
    endcase
    return cum;
  endfunction

endpackage

`default_nettype wire

/* sv/cdte_check.sv */
// ----------------------------------------------------------------------------
// cdte_check
// stage 1: field range checks, leap flag and year offset
// ----------------------------------------------------------------------------
`default_nettype none

module cdte_check (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire logic               in_valid,
  input  wire cdte_pkg::datetime_t in_data,
  output logic                    out_valid,
  output cdte_pkg::chk_t          out_data
);

  logic       year_ok;
  logic       leap;
  logic [4:0] len;
  logic       day_ok;
  logic       hms_ok;
  logic [11:0] yoff_full;

  always_comb begin
    year_ok   = (in_data.year >= 12'(cdte_pkg::YEAR_MIN)) &&
                (in_data.year <= 12'(cdte_pkg::YEAR_MAX));
    // inside the valid century every multiple of four is a leap year
    leap      = (in_data.year[1:0] == 2'b00);
    len       = cdte_pkg::month_len(in_data.month) +
                5'((in_data.month == 4'd2) && leap);
    day_ok    = (in_data.day != 6'd0) && (in_data.day <= {1'b0, len});
    hms_ok    = (in_data.hour < 6'd24) && (in_data.minute < 6'd60) &&
                (in_data.second < 6'd60);
    yoff_full = in_data.year - 12'(cdte_pkg::YEAR_MIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.ok     <= year_ok && day_ok && hms_ok;
      out_data.leap   <= leap;
      out_data.yoff   <= yoff_full[6:0];
      out_data.month  <= in_data.month;
      out_data.day    <= in_data.day[4:0];
      out_data.hour   <= in_data.hour[4:0];
      out_data.minute <= in_data.minute;
      out_data.second <= in_data.second;
    end
  end

endmodule

`default_nettype wire

/* sv/cdte_days.sv */
// ----------------------------------------------------------------------------
// cdte_days
// stage 2: day count since 1970-01-01 and seconds into the day
// ----------------------------------------------------------------------------
`default_nettype none

module cdte_days (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          load,
  input  wire logic          in_valid,
  input  wire cdte_pkg::chk_t in_data,
  output logic               out_valid,
  output cdte_pkg::days_t    out_data
);

  localparam int unsigned DW = cdte_pkg::DAYS_W;
  localparam int unsigned TW = cdte_pkg::TOD_W;

  logic [7:0]    leap_days;
  logic [DW-1:0] days;
  logic [TW-1:0] tod;

  always_comb begin
    // leap days in the years from 2000 up to but not including this one
    leap_days = (8'(in_data.yoff) + 8'd3) >> 2;
    days = DW'(cdte_pkg::DAYS_TO_Y2K)
         + DW'(in_data.yoff) * DW'(cdte_pkg::DAYS_PER_YEAR)
         + DW'(leap_days)
         + DW'(cdte_pkg::days_before_month(in_data.month))
         + DW'(in_data.leap && (in_data.month > 4'd2))
         + DW'(in_data.day) - DW'(1);
    tod  = TW'(in_data.hour) * TW'(cdte_pkg::SECS_PER_HOUR)
         + TW'(in_data.minute) * TW'(cdte_pkg::SECS_PER_MIN)
         + TW'(in_data.second);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.ok   <= in_data.ok;
      out_data.days <= days;
      out_data.tod  <= tod;
    end
  end

endmodule

`default_nettype wire

/* sv/cdte_mul.sv */
// ----------------------------------------------------------------------------
// cdte_mul
// stage 3: scale the day count to seconds
// ----------------------------------------------------------------------------
`default_nettype none

module cdte_mul (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic           in_valid,
  input  wire cdte_pkg::days_t in_data,
  output logic                out_valid,
  output cdte_pkg::prod_t     out_data
);

  localparam int unsigned PW = cdte_pkg::EPOCH_W + 1;

  logic [PW-1:0] prod_full;

  // valid dates stay below 2^32, so the top bit is dropped
  assign prod_full = PW'(in_data.days) * PW'(cdte_pkg::SECS_PER_DAY);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.ok   <= in_data.ok;
      out_data.prod <= prod_full[cdte_pkg::EPOCH_W-1:0];
      out_data.tod  <= in_data.tod;
    end
  end

endmodule

`default_nettype wire

/* sv/cdte_sum.sv */
// ----------------------------------------------------------------------------
// cdte_sum
// stage 4: add the time of day and zero the result of a rejected item
// ----------------------------------------------------------------------------
`default_nettype none

module cdte_sum (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           load,
  input  wire logic           in_valid,
  input  wire cdte_pkg::prod_t in_data,
  output logic                out_valid,
  output cdte_pkg::result_t   out_data
);

  localparam int unsigned EW = cdte_pkg::EPOCH_W;

  logic [EW-1:0] epoch;

  assign epoch = in_data.ok ? (in_data.prod + EW'(in_data.tod)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      out_data.valid_res <= in_data.ok;
      out_data.unix_time <= epoch;
    end
  end

endmodule

`default_nettype wire

/* sv/civil_datetime_to_epoch_top.sv */
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_top
// converts a checked utc date and time of the years 2000 to 2099 into unix
// epoch seconds
// ----------------------------------------------------------------------------
// Takes one date and time transaction per cycle while s_tready is high and
// returns exactly one result transaction for each, in order. Throughput is
// one transaction per clock while the output side is ready; the figure is set
// by the four-stage pipeline (field checks, day count and time of day, day to
// seconds multiply, final add), each stage holding its own valid bit. A stage
// refills as soon as it empties or passes its item on, so a stall on the
// output side fills the pipe and then holds s_tready low without losing or
// repeating anything. Any field out of range, including a day past the end of
// its month, gives valid_res 0 and unix_time 0.
// ----------------------------------------------------------------------------
`default_nettype none

module civil_datetime_to_epoch_top (
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // [11:0] year, [15:12] month, [21:16] day, [27:22] hour,
  // [33:28] minute, [39:34] second
  input  wire logic [39:0] s_tdata,
  // output stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [31:0] unix_time
  output logic [31:0]      m_tdata,
  // [0] valid_res
  output logic [0:0]       m_tuser
);

  // stage valid flags and payloads
  logic                 v1, v2, v3, v4;
  cdte_pkg::chk_t       d1;
  cdte_pkg::days_t      d2;
  cdte_pkg::prod_t      d3;
  cdte_pkg::result_t    d4;
  cdte_pkg::datetime_t  in_item;

  // per-stage load enables: a stage takes new data when empty or draining
  logic                 ld1, ld2, ld3, ld4;

  assign in_item = cdte_pkg::datetime_t'(s_tdata);

  assign ld4 = !v4 || m_tready;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;
  assign ld1 = !v1 || ld2;

  assign s_tready = ld1;

  // field checks
  cdte_check u_check (
    .clk       (clk),
    .rst       (rst),
    .load      (ld1),
    .in_valid  (s_tvalid),
    .in_data   (in_item),
    .out_valid (v1),
    .out_data  (d1)
  );

  // day count and seconds into the day
  cdte_days u_days (
    .clk       (clk),
    .rst       (rst),
    .load      (ld2),
    .in_valid  (v1),
    .in_data   (d1),
    .out_valid (v2),
    .out_data  (d2)
  );

  // days to seconds
  cdte_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .load      (ld3),
    .in_valid  (v2),
    .in_data   (d2),
    .out_valid (v3),
    .out_data  (d3)
  );

  // final sum, doubles as the output register
  cdte_sum u_sum (
    .clk       (clk),
    .rst       (rst),
    .load      (ld4),
    .in_valid  (v3),
    .in_data   (d3),
    .out_valid (v4),
    .out_data  (d4)
  );

  assign m_tvalid = v4;
  assign m_tdata  = d4.unix_time;
  assign m_tuser  = d4.valid_res;

endmodule

`default_nettype wire

/* verif/epoch_checker.sv */
// ----------------------------------------------------------------------------
// epoch_checker
// watches both stream channels, predicts the epoch result of every accepted
// datetime transaction and compares it with the results in arrival order
// ----------------------------------------------------------------------------

module epoch_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  // [11:0] year, [15:12] month, [21:16] day, [27:22] hour,
  // [33:28] minute, [39:34] second
  input  logic [39:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  // [31:0] unix_time
  input  logic [31:0] m_tdata,
  // [0] valid_res
  input  logic [0:0]  m_tuser,
  output int          errors,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  cdte_pkg::result_t expected_epochs[$];

  function automatic bit is_leap(input int unsigned y);
    return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
  endfunction

  function automatic int unsigned month_length(input int unsigned y, input int unsigned m);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = is_leap(y) ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  // field checks, then era-based day count since 1970-01-01
  function automatic cdte_pkg::result_t predict_epoch(input cdte_pkg::datetime_t dt);
    cdte_pkg::result_t res;
    int unsigned y, m, d, ys, era, yoe, mp, doy, doe;
    longint      days;
    longint      secs;
    bit          ok;
    y  = 32'(dt.year);
    m  = 32'(dt.month);
    d  = 32'(dt.day);
    ok = (y >= cdte_pkg::YEAR_MIN) && (y <= cdte_pkg::YEAR_MAX) && (m >= 1) && (m <= 12) &&
         (d >= 1) && (d <= month_length(y, m)) &&
         (dt.hour < 24) && (dt.minute < 60) && (dt.second < 60);
    res.valid_res = ok;
    res.unix_time = '0;
    if (ok) begin
      ys   = (m <= 2) ? y - 1 : y;
      era  = ys / 400;
      yoe  = ys - era * 400;
      mp   = (m > 2) ? m - 3 : m + 9;
      doy  = (153 * mp + 2) / 5 + d - 1;
      doe  = yoe * 365 + yoe / 4 - yoe / 100 + doy;
      days = longint'(era) * 146097 + longint'(doe) - 719468;
      secs = days * 86400 + longint'(dt.hour) * 3600 + longint'(dt.minute) * 60 +
             longint'(dt.second);
      res.unix_time = secs[31:0];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    cdte_pkg::result_t want;
    if (rst) begin
      expected_epochs.delete();
      errors = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_epochs.size() == 0) begin
          errors = errors + 1;
          $display("%0t: unexpected result, expected none, got valid %0b epoch %0d",
                   $time, m_tuser[0], m_tdata);
        end else begin
          want = expected_epochs.pop_front();
          if (m_tuser[0] !== want.valid_res) begin
            errors = errors + 1;
            $display("%0t: valid_res mismatch, expected %0b, got %0b",
                     $time, want.valid_res, m_tuser[0]);
          end
          if (m_tdata !== want.unix_time) begin
            errors = errors + 1;
            $display("%0t: unix_time mismatch, expected %0d, got %0d",
                     $time, want.unix_time, m_tdata);
          end
        end
      end
      if (s_tvalid && s_tready)
        expected_epochs.push_back(predict_epoch(cdte_pkg::datetime_t'(s_tdata)));
    end
    outstanding = expected_epochs.size();
  end

endmodule

/* verif/civil_datetime_to_epoch_top_test.sv */
// ----------------------------------------------------------------------------
// civil_datetime_to_epoch_top_test
// stimulus and verdict for the datetime-to-epoch pipeline
// ----------------------------------------------------------------------------
// Sends a directed set of calendar corner cases, then random dates that are
// mostly well formed with some out-of-range fields and raw noise mixed in.
// Both stream sides idle at random in chunks, some chunks without gaps. The
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------

module civil_datetime_to_epoch_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1400;
  localparam int CHUNK_ITEMS  = 100;
  // no transaction on either side for this many cycles ends the run
  localparam int IDLE_LIMIT   = 5000;
  // pipeline is four stages deep, give it a little more after draining
  localparam int DRAIN_CYCLES = 12;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;

  bit send_gaps   = 1'b1;  // input side idles between transactions
  bit stall_on    = 1'b1;  // output side drops tready at random
  int stall_left  = 0;
  int idle_cycles = 0;
  int errors;
  int outstanding;

  always #2 clk = ~clk;

  civil_datetime_to_epoch_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  epoch_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic cdte_pkg::datetime_t mk_datetime(input int y, input int mo, input int d,
                                                      input int h, input int mi, input int s);
    cdte_pkg::datetime_t dt;
    dt.year   = 12'(y);
    dt.month  = 4'(mo);
    dt.day    = 6'(d);
    dt.hour   = 6'(h);
    dt.minute = 6'(mi);
    dt.second = 6'(s);
    return dt;
  endfunction

  // date with random in-range fields, raw noise, or one field pushed out of range
  function automatic cdte_pkg::datetime_t random_datetime();
    cdte_pkg::datetime_t dt;
    int                  kind;
    logic [63:0]         raw;
    kind      = $urandom_range(0, 99);
    dt.year   = 12'($urandom_range(cdte_pkg::YEAR_MIN, cdte_pkg::YEAR_MAX));
    dt.month  = 4'($urandom_range(1, 12));
    // days 29 to 31 hit both month ends and days past the end
    dt.day    = 6'(($urandom_range(0, 3) == 0) ? $urandom_range(29, 31)
                                               : $urandom_range(1, 28));
    dt.hour   = 6'($urandom_range(0, 23));
    dt.minute = 6'($urandom_range(0, 59));
    dt.second = 6'($urandom_range(0, 59));
    if (kind < 70) begin
      // keep the well-formed date
    end else if (kind < 76) begin
      raw = {$urandom(), $urandom()};
      dt  = raw[39:0];
    end else if (kind < 80) begin
      do dt.year = 12'($urandom_range(0, 4095));
      while (dt.year >= cdte_pkg::YEAR_MIN && dt.year <= cdte_pkg::YEAR_MAX);
    end else if (kind < 84) begin
      dt.month = 4'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(13, 15));
    end else if (kind < 88) begin
      dt.day = 6'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(32, 63));
    end else if (kind < 92) begin
      dt.hour = 6'($urandom_range(24, 63));
    end else if (kind < 96) begin
      dt.minute = 6'($urandom_range(60, 63));
    end else begin
      dt.second = 6'($urandom_range(60, 63));
    end
    return dt;
  endfunction

  // one input transaction: drive at the falling edge, hold until accepted
  task automatic send_datetime(input cdte_pkg::datetime_t dt);
    int gap;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= dt;
    do @(posedge clk); while (!s_tready);
    gap = send_gaps ? pick_gap() : 0;
    // with no gap tvalid stays high into the next transaction
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
  endtask

  // output side backpressure
  initial begin
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        m_tready   <= 1'b0;
        stall_left = stall_left - 1;
      end else begin
        m_tready <= 1'b1;
        if (stall_on && $urandom_range(0, 99) < 20)
          stall_left = pick_gap() + 1;
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    cdte_pkg::datetime_t directed[$];
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // range ends of the result
    directed.push_back(mk_datetime(2000, 1, 1, 0, 0, 0));
    directed.push_back(mk_datetime(2099, 12, 31, 23, 59, 59));
    // leap years: divisible by 400, plain leap, common year
    directed.push_back(mk_datetime(2000, 2, 29, 12, 30, 30));
    directed.push_back(mk_datetime(2004, 2, 29, 0, 0, 1));
    directed.push_back(mk_datetime(2096, 2, 29, 23, 0, 0));
    directed.push_back(mk_datetime(2001, 2, 28, 1, 2, 3));
    directed.push_back(mk_datetime(2001, 2, 29, 1, 2, 3));
    // year just outside and at the field ends
    directed.push_back(mk_datetime(1999, 12, 31, 23, 59, 59));
    directed.push_back(mk_datetime(2100, 2, 29, 0, 0, 0));
    directed.push_back(mk_datetime(0, 1, 1, 0, 0, 0));
    directed.push_back(mk_datetime(4095, 15, 63, 63, 63, 63));
    // month codes that are not a month
    directed.push_back(mk_datetime(2050, 0, 1, 0, 0, 0));
    directed.push_back(mk_datetime(2050, 13, 1, 0, 0, 0));
    directed.push_back(mk_datetime(2050, 15, 1, 0, 0, 0));
    // day at zero, at month end and past it
    directed.push_back(mk_datetime(2050, 4, 0, 0, 0, 0));
    directed.push_back(mk_datetime(2050, 4, 30, 0, 0, 0));
    directed.push_back(mk_datetime(2050, 4, 31, 0, 0, 0));
    directed.push_back(mk_datetime(2050, 1, 63, 0, 0, 0));
    // march starts the shifted year, january still in the previous one
    directed.push_back(mk_datetime(2024, 3, 1, 0, 0, 0));
    directed.push_back(mk_datetime(2024, 1, 31, 23, 59, 59));
    // time of day limits
    directed.push_back(mk_datetime(2070, 6, 15, 24, 0, 0));
    directed.push_back(mk_datetime(2070, 6, 15, 63, 0, 0));
    directed.push_back(mk_datetime(2070, 6, 15, 0, 60, 0));
    directed.push_back(mk_datetime(2070, 6, 15, 0, 63, 0));
    directed.push_back(mk_datetime(2070, 6, 15, 0, 0, 60));
    directed.push_back(mk_datetime(2070, 6, 15, 0, 0, 63));

    foreach (directed[i])
      send_datetime(directed[i]);

    // random part in chunks, each with its own idling pattern
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % CHUNK_ITEMS == 0) begin
        send_gaps = ($urandom_range(0, 3) != 0);
        stall_on  = ($urandom_range(0, 3) != 0);
      end
      send_datetime(random_datetime());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    stall_on = 1'b1;

    // let every expected result come out, then a few more cycles
    while (outstanding != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (errors == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/cdte_pkg.sv
sv/cdte_check.sv
sv/cdte_days.sv
sv/cdte_mul.sv
sv/cdte_sum.sv
sv/civil_datetime_to_epoch_top.sv
verif/epoch_checker.sv
verif/civil_datetime_to_epoch_top_test.sv
